@@ rtl/core/fcsg_pkg.sv @@
`default_nettype none
package fcsg_pkg;

   localparam int MAX_RADIUS  = 19;
   localparam int RADIUS_W    = 5;
   localparam int COORD_IN_W  = 11;
   localparam int COORD_OUT_W = 12;

   // Walk values: ox and oy as small signed words, decision term wider
   localparam int WALK_W      = 6;
   localparam int DECISION_W  = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] center_x;
      logic signed [COORD_IN_W-1:0] center_y;
      logic        [RADIUS_W-1:0]   radius;
   } circle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Order of the four spans of one walk step
   typedef enum logic [1:0] {
      SLOT_PLUS_X  = 2'd0,
      SLOT_PLUS_Y  = 2'd1,
      SLOT_MINUS_Y = 2'd2,
      SLOT_MINUS_X = 2'd3
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } walk_state_type;

endpackage
`default_nettype wire

@@ rtl/core/fcsg_front.sv @@
`default_nettype none
module fcsg_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [fcsg_pkg::COORD_IN_W-1:0] req_center_x,
   input  wire logic signed [fcsg_pkg::COORD_IN_W-1:0] req_center_y,
   input  wire logic        [fcsg_pkg::RADIUS_W-1:0]   req_radius,
   input  wire fcsg_pkg::queue_status_type           queue_status,
   output logic                                      busy,
   output logic                                      front_valid,
   output logic                                      push,
   output fcsg_pkg::circle_type                      push_data
);
   import fcsg_pkg::*;

   logic       front_valid_ff, front_valid_in;
   circle_type front_data_ff,  front_data_in;
   logic       ready;
   logic       accept;

   assign push   = front_valid_ff && !queue_status.full;
   assign ready  = !front_valid_ff || !queue_status.full;
   assign accept = start && ready;

   always_comb begin
      front_data_in = front_data_ff;
      if (accept) begin
         front_data_in.center_x = req_center_x;
         front_data_in.center_y = req_center_y;
         // clamp oversized radius
         if (req_radius > RADIUS_W'(MAX_RADIUS)) begin
            front_data_in.radius = RADIUS_W'(MAX_RADIUS);
         end else begin
            front_data_in.radius = req_radius;
         end
      end
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_data_ff <= front_data_in;
   end

   assign busy        = !ready;
   assign front_valid = front_valid_ff;
   assign push_data   = front_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/fcsg_queue.sv @@
`default_nettype none
module fcsg_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire fcsg_pkg::circle_type       push_data,
   input  wire logic                       pop,
   output fcsg_pkg::circle_type            pop_data,
   output fcsg_pkg::queue_status_type      status
);
   import fcsg_pkg::*;

   circle_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff,  count_in;
   logic                     do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

@@ rtl/core/fcsg_walk.sv @@
`default_nettype none
module fcsg_walk (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fcsg_pkg::queue_status_type             queue_status,
   input  wire fcsg_pkg::circle_type                   pop_data,
   output logic                                        pop,
   output logic                                        rsp_valid,
   output logic signed [fcsg_pkg::COORD_OUT_W-1:0]     rsp_span_row,
   output logic signed [fcsg_pkg::COORD_OUT_W-1:0]     rsp_span_left,
   output logic signed [fcsg_pkg::COORD_OUT_W-1:0]     rsp_span_right,
   output logic                                        rsp_last_span
);
   import fcsg_pkg::*;

   walk_state_type                 st_ff,    st_in;
   slot_type                       slot_ff,  slot_in;
   logic signed [WALK_W-1:0]       ox_ff,    ox_in;
   logic signed [WALK_W-1:0]       oy_ff,    oy_in;
   logic signed [DECISION_W-1:0]   d_ff,     d_in;
   circle_type                     circ_ff,  circ_in;

   logic                           valid_ff, valid_in;
   logic signed [COORD_OUT_W-1:0]  row_ff,   row_in;
   logic signed [COORD_OUT_W-1:0]  left_ff,  left_in;
   logic signed [COORD_OUT_W-1:0]  right_ff, right_in;
   logic                           last_ff,  last_in;

   logic signed [DECISION_W-1:0]   ox_w, oy_w, r_w;
   logic signed [WALK_W-1:0]       ox_nx, oy_nx;
   logic signed [DECISION_W-1:0]   d_nx;
   logic signed [COORD_OUT_W-1:0]  cx_w, cy_w, off_w, half_w;
   logic                           walk_done;

   assign pop = (st_ff == ST_IDLE) && !queue_status.empty;

   assign ox_w = DECISION_W'(ox_ff);
   assign oy_w = DECISION_W'(oy_ff);
   assign r_w  = DECISION_W'($signed({1'b0, circ_ff.radius}));

   // Andres decision rules
   always_comb begin
      if (d_ff >= (ox_w + ox_w)) begin
         d_nx  = d_ff - (ox_w + ox_w + DECISION_W'(1));
         ox_nx = ox_ff + WALK_W'(1);
         oy_nx = oy_ff;
      end else if (d_ff < ((r_w - oy_w) + (r_w - oy_w))) begin
         d_nx  = d_ff + (oy_w + oy_w - DECISION_W'(1));
         ox_nx = ox_ff;
         oy_nx = oy_ff - WALK_W'(1);
      end else begin
         d_nx  = d_ff + ((oy_w - ox_w - DECISION_W'(1)) + (oy_w - ox_w - DECISION_W'(1)));
         ox_nx = ox_ff + WALK_W'(1);
         oy_nx = oy_ff - WALK_W'(1);
      end
   end

   assign walk_done = (oy_nx < ox_nx);

   assign cx_w = COORD_OUT_W'(circ_ff.center_x);
   assign cy_w = COORD_OUT_W'(circ_ff.center_y);

   always_comb begin
      unique case (slot_ff)
         SLOT_PLUS_X: begin
            off_w  = COORD_OUT_W'(ox_ff);
            half_w = COORD_OUT_W'(oy_ff);
         end
         SLOT_PLUS_Y: begin
            off_w  = COORD_OUT_W'(oy_ff);
            half_w = COORD_OUT_W'(ox_ff);
         end
         SLOT_MINUS_Y: begin
            off_w  = -COORD_OUT_W'(oy_ff);
            half_w = COORD_OUT_W'(ox_ff);
         end
         SLOT_MINUS_X: begin
            off_w  = -COORD_OUT_W'(ox_ff);
            half_w = COORD_OUT_W'(oy_ff);
         end
         default: begin
            off_w  = '0;
            half_w = '0;
         end
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      slot_in  = slot_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      d_in     = d_ff;
      circ_in  = circ_ff;
      valid_in = 1'b0;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (pop) begin
               circ_in = pop_data;
               ox_in   = '0;
               oy_in   = WALK_W'($signed({1'b0, pop_data.radius}));
               d_in    = DECISION_W'($signed({1'b0, pop_data.radius})) - DECISION_W'(1);
               slot_in = SLOT_PLUS_X;
               st_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            valid_in = 1'b1;
            row_in   = cy_w + off_w;
            left_in  = cx_w - half_w;
            right_in = cx_w + half_w;
            slot_in  = slot_type'(slot_ff + 2'd1);
            if (slot_ff == SLOT_MINUS_X) begin
               ox_in   = ox_nx;
               oy_in   = oy_nx;
               d_in    = d_nx;
               last_in = walk_done;
               if (walk_done) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         slot_ff  <= SLOT_PLUS_X;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      d_ff     <= d_in;
      circ_ff  <= circ_in;
      row_ff   <= row_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_span_row   = row_ff;
   assign rsp_span_left  = left_ff;
   assign rsp_span_right = right_ff;
   assign rsp_last_span  = last_ff;

endmodule
`default_nettype wire

@@ rtl/core/filled_circle_span_generator_top.sv @@
// Filled circle span generator.
//
// Request channel: drive req_center_x, req_center_y and req_radius with start
// high; the transaction is taken at a rising edge where start is high and
// busy is low. A radius above the largest supported value is clamped to it.
// Response channel: each horizontal span appears on the rsp_ ports for one
// cycle, flagged by rsp_valid; rsp_last_span marks the final span of a
// circle. The receiver cannot stall, so spans simply stream out.
// Path: the first span of a circle passes the front register, the queue
// entry, the walker state and the output register, if the queue is empty
// and the walker idle. Throughput: one span per cycle while walking, four
// spans per walk step (15 steps at radius 19), then back to idle for the
// next circle. The walker's one-span-per-cycle loop sets the rate.
// A front register and a two-entry queue let further requests be taken
// while a circle is being walked; busy rises once both are full.
// Reset: synchronous, active high; drops any queued circles and the walk in
// progress, and leaves rsp_valid low.
`default_nettype none
module filled_circle_span_generator_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [fcsg_pkg::COORD_IN_W-1:0] req_center_x,
   input  wire logic signed [fcsg_pkg::COORD_IN_W-1:0] req_center_y,
   input  wire logic        [fcsg_pkg::RADIUS_W-1:0]   req_radius,
   output logic                                        rsp_valid,
   output logic signed [fcsg_pkg::COORD_OUT_W-1:0]     rsp_span_row,
   output logic signed [fcsg_pkg::COORD_OUT_W-1:0]     rsp_span_left,
   output logic signed [fcsg_pkg::COORD_OUT_W-1:0]     rsp_span_right,
   output logic                                        rsp_last_span
);
   import fcsg_pkg::*;

   queue_status_type queue_status;
   circle_type       push_data;
   circle_type       pop_data;
   logic             push;
   logic             pop;
   logic             front_valid;

   // Front: take the request, clamp the radius, hand it to the queue
   fcsg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .queue_status (queue_status),
      .busy         (busy),
      .front_valid  (front_valid),
      .push         (push),
      .push_data    (push_data)
   );

   // Hold circles between front and walker
   fcsg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .status   (queue_status)
   );

   // Back: walk the circle and stream spans, one per cycle while walking
   fcsg_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .pop_data       (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_left  (rsp_span_left),
      .rsp_span_right (rsp_span_right),
      .rsp_last_span  (rsp_last_span)
   );

   // The walker goes idle after the final span of a circle, so no span is issued in the cycle after it
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_span |=> !rsp_valid)
      else $error("span issued straight after the last span of a circle");

   // Never pop an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("walker popped an empty queue");

   // Busy only while the front holds a circle the queue cannot take
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      busy |-> front_valid && queue_status.full)
      else $error("busy raised without a blocked front register");

endmodule
`default_nettype wire
